// ===== src/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vpa_pkg;

  localparam int DEF_MAX_TASKS   = 8;
  localparam int DEF_TOTAL_UNITS = 1024;
  localparam int DEF_PAGE_COUNT  = 256;

  localparam int PCT_SCALE = 100;

  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 3;
  localparam int POLICY_W = 2;
  localparam int FRAG_W   = 7;
  localparam int PAGES_W  = 9;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NO_FIT   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_MATCH = 3'd4
  } status_t;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_STEP,
    OP_FAIL,
    OP_SPLIT,
    OP_TAKE,
    OP_RELEASE,
    OP_MERGE_INIT,
    OP_MERGE_STEP,
    OP_STAT_INIT,
    OP_STAT_STEP,
    OP_FRAG_ZERO,
    OP_FRAG_START,
    OP_FRAG_SAVE,
    OP_PAGE_SAVE,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
  } ctl_t;

  typedef struct packed {
    logic zero_size;
    logic is_free;
    logic scan_last;
    logic found;
    logic need_split;
    logic full;
    logic merge_last;
    logic stat_last;
    logic frag_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/vpa_divider.sv =====
// ----------------------------------------------------------------------------
// vpa_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_divider #(
  parameter int DW = 18,
  parameter int VW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] q;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          ge;

  assign rem_sh   = {rem, q[DW-1]};
  assign diff     = rem_sh - {1'b0, divisor};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DW);
        q   <= dividend;
        rem <= '0;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
        q   <= {q[DW-2:0], ge};
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/vpa_datapath.sv =====
// ----------------------------------------------------------------------------
// vpa_datapath
// Partition table, scan and merge registers, statistics and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_datapath #(
  parameter int MAX_TASKS   = vpa_pkg::DEF_MAX_TASKS,
  parameter int TOTAL_UNITS = vpa_pkg::DEF_TOTAL_UNITS,
  parameter int PAGE_COUNT  = vpa_pkg::DEF_PAGE_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vpa_pkg::ctl_t                 ctl,
  output vpa_pkg::sts_t                      sts,
  input  wire logic                          cfg_we,
  input  wire logic [vpa_pkg::POLICY_W-1:0]  cfg_data,
  input  wire logic                          cmd,
  input  wire logic [vpa_pkg::SIZE_W-1:0]    request_size,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vpa_pkg::STATUS_W-1:0]       status,
  output logic [vpa_pkg::SIZE_W-1:0]         used_units,
  output logic [vpa_pkg::SIZE_W-1:0]         free_units,
  output logic [vpa_pkg::SIZE_W-1:0]         largest_free,
  output logic [vpa_pkg::FRAG_W-1:0]         fragmentation_pct,
  output logic [vpa_pkg::PAGES_W-1:0]        free_pages
);

  import vpa_pkg::*;

  localparam int DEPTH  = 2 * MAX_TASKS + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int TU_W   = $clog2(TOTAL_UNITS + 1);
  localparam int LEN_W  = (TU_W > SIZE_W) ? TU_W : SIZE_W;
  localparam int PG_W   = $clog2(PAGE_COUNT + 1);
  localparam int FR_DW  = LEN_W + FRAG_W;
  localparam int PG_DW  = LEN_W + PG_W;
  localparam int DVD_W  = FR_DW;
  localparam int PW     = (PG_W > PAGES_W) ? PG_W : PAGES_W;
  localparam int RSH    = PG_DW + $clog2(TOTAL_UNITS);
  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(TOTAL_UNITS) - 64'd1) / 64'(TOTAL_UNITS);
  localparam int RC_W   = PG_DW + 2;
  localparam int RP_W   = PG_DW + RC_W;

  logic [LEN_W-1:0] blk_start [DEPTH];
  logic [LEN_W-1:0] blk_len   [DEPTH];
  logic             blk_taken [DEPTH];
  logic [CNT_W-1:0] entry_cnt;
  logic [LEN_W-1:0] used;
  logic [POLICY_W-1:0] policy;

  logic             op_free;
  logic [SIZE_W-1:0] size_q;
  status_t          st;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] mi;
  logic             found;
  logic [IDX_W-1:0] sel;
  logic [LEN_W-1:0] sel_len;
  logic [LEN_W-1:0] sel_start;
  logic             xfound;
  logic [IDX_W-1:0] xsel;
  logic             prev_taken;
  logic [LEN_W-1:0] prev_len;
  logic [LEN_W-1:0] fsum;
  logic [LEN_W-1:0] lmax;
  logic [PG_DW-1:0] prod;
  logic [FRAG_W-1:0] frag;
  logic [PAGES_W-1:0] pages;

  logic [IDX_W-1:0] rd_idx;
  logic [LEN_W-1:0] rd_len;
  logic [LEN_W-1:0] rd_start;
  logic             rd_taken;
  logic [LEN_W-1:0] size_ext;
  logic [CNT_W-1:0] ptr1;
  logic [CNT_W-1:0] sel1;
  logic             cand;
  logic             ff_hit;
  logic [IDX_W-1:0] rsel;
  logic [LEN_W-1:0] rlen;
  logic [LEN_W-1:0] mlen;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [RP_W-1:0]  share_prod;
  logic [PG_DW-1:0] share;
  logic [PW-1:0]    pages_w;

  assign rd_idx   = (ptr < IDX_W'(DEPTH)) ? ptr : '0;
  assign rd_len   = blk_len[rd_idx];
  assign rd_start = blk_start[rd_idx];
  assign rd_taken = blk_taken[rd_idx];
  assign size_ext = LEN_W'(size_q);
  assign ptr1     = CNT_W'(ptr) + 1'b1;
  assign sel1     = CNT_W'(sel) + 1'b1;
  assign cand     = !rd_taken && (rd_len >= size_ext);
  assign ff_hit   = !op_free && (policy == POL_FIRST) && cand;
  assign rsel     = xfound ? xsel : sel;
  assign rlen     = xfound ? size_ext : sel_len;
  assign mlen     = prev_len + rd_len;

  assign sts.zero_size  = (st == ST_ZERO);
  assign sts.is_free    = op_free;
  assign sts.scan_last  = (ptr1 >= entry_cnt) || ff_hit;
  assign sts.found      = found;
  assign sts.need_split = sel_len > size_ext;
  assign sts.full       = entry_cnt >= CNT_W'(DEPTH);
  assign sts.merge_last = CNT_W'(ptr) >= entry_cnt;
  assign sts.stat_last  = ptr1 >= entry_cnt;
  assign sts.frag_zero  = (used == '0) || (fsum == '0);
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || !out_stall;

  assign div_start = (ctl.op == OP_FRAG_START);
  assign div_dvd   = DVD_W'(fsum - lmax) * DVD_W'(PCT_SCALE);

  vpa_divider #(
    .DW (DVD_W),
    .VW (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (fsum),
    .done     (div_done),
    .quotient (div_q)
  );

  // page share by reciprocal multiplication, exact for every product value
  assign share_prod = RP_W'(prod) * RP_W'(RECIP);
  assign share      = PG_DW'(share_prod >> RSH);
  assign pages_w    = (share >= PG_DW'(PAGE_COUNT)) ? '0 :
                      (PW'(PAGE_COUNT) - PW'(share));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DEPTH; j++) begin
        blk_taken[j] <= 1'b0;
      end
      blk_start[0] <= '0;
      blk_len[0]   <= LEN_W'(TOTAL_UNITS);
      entry_cnt    <= CNT_W'(1);
      used         <= '0;
      policy       <= POL_FIRST;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we && (cfg_data == POL_FIRST || cfg_data == POL_BEST || cfg_data == POL_WORST)) begin
        policy <= cfg_data;
      end
      if (ctl.op == OP_OUT_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (ctl.op)
        OP_LOAD: begin
          op_free <= cmd;
          size_q  <= request_size;
          st      <= (request_size == '0) ? ST_ZERO : ST_OK;
          ptr     <= '0;
          found   <= 1'b0;
          xfound  <= 1'b0;
          sel     <= '0;
          sel_len <= '0;
        end
        OP_SCAN_STEP: begin
          ptr <= ptr + 1'b1;
          if (!op_free) begin
            if (cand && (!found || (policy == POL_BEST && rd_len < sel_len) ||
                         (policy == POL_WORST && rd_len > sel_len))) begin
              found     <= 1'b1;
              sel       <= ptr;
              sel_len   <= rd_len;
              sel_start <= rd_start;
            end
          end else begin
            if (rd_taken && rd_len == size_ext && !xfound) begin
              xfound <= 1'b1;
              xsel   <= ptr;
            end
            if (rd_taken && rd_len >= size_ext && !found) begin
              found   <= 1'b1;
              sel     <= ptr;
              sel_len <= rd_len;
            end
          end
        end
        OP_FAIL: begin
          st <= ctl.code;
        end
        OP_SPLIT: begin
          for (int j = 0; j < DEPTH; j++) begin
            if (CNT_W'(j) == CNT_W'(sel)) begin
              blk_len[j]   <= size_ext;
              blk_taken[j] <= 1'b1;
            end else if (CNT_W'(j) == sel1) begin
              blk_start[j] <= sel_start + size_ext;
              blk_len[j]   <= sel_len - size_ext;
              blk_taken[j] <= 1'b0;
            end else if (j > 0 && CNT_W'(j) > sel1 && CNT_W'(j) <= entry_cnt) begin
              blk_start[j] <= blk_start[(j > 0) ? j - 1 : 0];
              blk_len[j]   <= blk_len[(j > 0) ? j - 1 : 0];
              blk_taken[j] <= blk_taken[(j > 0) ? j - 1 : 0];
            end
          end
          entry_cnt <= entry_cnt + 1'b1;
          used      <= used + size_ext;
        end
        OP_TAKE: begin
          blk_taken[sel] <= 1'b1;
          used           <= used + size_ext;
        end
        OP_RELEASE: begin
          blk_taken[rsel] <= 1'b0;
          used            <= (used >= rlen) ? used - rlen : '0;
        end
        OP_MERGE_INIT: begin
          mi         <= '0;
          ptr        <= IDX_W'(1);
          prev_taken <= blk_taken[0];
          prev_len   <= blk_len[0];
        end
        OP_MERGE_STEP: begin
          if (!prev_taken && !rd_taken) begin
            blk_len[mi] <= mlen;
            prev_len    <= mlen;
            for (int j = 0; j < DEPTH - 1; j++) begin
              if (CNT_W'(j) >= CNT_W'(ptr) && CNT_W'(j + 1) < entry_cnt) begin
                blk_start[j] <= blk_start[j + 1];
                blk_len[j]   <= blk_len[j + 1];
                blk_taken[j] <= blk_taken[j + 1];
              end
            end
            entry_cnt <= entry_cnt - 1'b1;
          end else begin
            mi         <= ptr;
            ptr        <= ptr + 1'b1;
            prev_taken <= rd_taken;
            prev_len   <= rd_len;
          end
        end
        OP_STAT_INIT: begin
          ptr  <= '0;
          fsum <= '0;
          lmax <= '0;
          prod <= PG_DW'(used) * PG_DW'(PAGE_COUNT);
        end
        OP_STAT_STEP: begin
          ptr <= ptr + 1'b1;
          if (!rd_taken) begin
            fsum <= fsum + rd_len;
            if (rd_len > lmax) begin
              lmax <= rd_len;
            end
          end
        end
        OP_FRAG_ZERO: begin
          frag <= '0;
        end
        OP_FRAG_SAVE: begin
          frag <= div_q[FRAG_W-1:0];
        end
        OP_PAGE_SAVE: begin
          pages <= pages_w[PAGES_W-1:0];
        end
        OP_OUT_LOAD: begin
          status            <= st;
          used_units        <= used[SIZE_W-1:0];
          free_units        <= fsum[SIZE_W-1:0];
          largest_free      <= lmax[SIZE_W-1:0];
          fragmentation_pct <= frag;
          free_pages        <= pages;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/vpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer of the allocator: scan, update, merge, statistics, result.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire vpa_pkg::sts_t sts,
  output vpa_pkg::ctl_t      ctl
);

  import vpa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_MERGE_INIT,
    S_MERGE,
    S_STAT_INIT,
    S_STAT,
    S_FRAG,
    S_FRAG_WAIT,
    S_PAGES,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    ctl.code   = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.zero_size ? S_STAT_INIT : S_SCAN;
      end
      S_SCAN: begin
        ctl.op = OP_SCAN_STEP;
        if (sts.scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_STAT_INIT;
        if (sts.is_free) begin
          if (!sts.found) begin
            ctl.op   = OP_FAIL;
            ctl.code = ST_NO_MATCH;
          end else begin
            ctl.op     = OP_RELEASE;
            state_next = S_MERGE_INIT;
          end
        end else if (!sts.found) begin
          ctl.op   = OP_FAIL;
          ctl.code = ST_NO_FIT;
        end else if (sts.need_split && sts.full) begin
          ctl.op   = OP_FAIL;
          ctl.code = ST_FULL;
        end else if (sts.need_split) begin
          ctl.op = OP_SPLIT;
        end else begin
          ctl.op = OP_TAKE;
        end
      end
      S_MERGE_INIT: begin
        ctl.op     = OP_MERGE_INIT;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if (sts.merge_last) begin
          state_next = S_STAT_INIT;
        end else begin
          ctl.op = OP_MERGE_STEP;
        end
      end
      S_STAT_INIT: begin
        ctl.op     = OP_STAT_INIT;
        state_next = S_STAT;
      end
      S_STAT: begin
        ctl.op = OP_STAT_STEP;
        if (sts.stat_last) begin
          state_next = S_FRAG;
        end
      end
      S_FRAG: begin
        if (sts.frag_zero) begin
          ctl.op     = OP_FRAG_ZERO;
          state_next = S_PAGES;
        end else begin
          ctl.op     = OP_FRAG_START;
          state_next = S_FRAG_WAIT;
        end
      end
      S_FRAG_WAIT: begin
        if (sts.div_done) begin
          ctl.op     = OP_FRAG_SAVE;
          state_next = S_PAGES;
        end
      end
      S_PAGES: begin
        ctl.op     = OP_PAGE_SAVE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/variable_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Contiguous partition allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// One request at a time. A request makes a scan pass over the table entries
// (cut short by first fit) and a statistics pass, one entry per cycle, and
// the restoring divider produces one quotient bit per cycle for the
// fragmentation percentage (its dividend is 18 bits wide at the default
// sizes; the division is skipped when no unit is used or none is free). A
// free adds a merge walk. The free page count comes from a single reciprocal
// multiplication. The result register lets a new request be taken while the
// previous result is still stalled.
`default_nettype none

module variable_partition_allocator #(
  parameter int MAX_TASKS   = vpa_pkg::DEF_MAX_TASKS,
  parameter int TOTAL_UNITS = vpa_pkg::DEF_TOTAL_UNITS,
  parameter int PAGE_COUNT  = vpa_pkg::DEF_PAGE_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [vpa_pkg::POLICY_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          cmd,
  input  wire logic [vpa_pkg::SIZE_W-1:0]    request_size,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [vpa_pkg::STATUS_W-1:0]       status,
  output logic [vpa_pkg::SIZE_W-1:0]         used_units,
  output logic [vpa_pkg::SIZE_W-1:0]         free_units,
  output logic [vpa_pkg::SIZE_W-1:0]         largest_free,
  output logic [vpa_pkg::FRAG_W-1:0]         fragmentation_pct,
  output logic [vpa_pkg::PAGES_W-1:0]        free_pages
);

  import vpa_pkg::*;

  ctl_t ctl;
  sts_t sts;

  vpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  vpa_datapath #(
    .MAX_TASKS   (MAX_TASKS),
    .TOTAL_UNITS (TOTAL_UNITS),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .request_size      (request_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .used_units        (used_units),
    .free_units        (free_units),
    .largest_free      (largest_free),
    .fragmentation_pct (fragmentation_pct),
    .free_pages        (free_pages)
  );

endmodule

`default_nettype wire
